FILE: design/sector_allocation_table_assert.svh
// assertion macros shared by the checker
`ifndef SECTOR_ALLOCATION_TABLE_ASSERT_SVH
`define SECTOR_ALLOCATION_TABLE_ASSERT_SVH

// antecedent holds, consequent in the next cycle
`define SAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sector allocation table: next-cycle check failed");

// antecedent holds, consequent in the same cycle
`define SAT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sector allocation table: same-cycle check failed");

`endif

FILE: design/sat_pkg.sv
package sat_pkg;

  localparam int NUM_SECTORS = 64;
  localparam int ID_W        = 16;
  localparam int AW          = $clog2(NUM_SECTORS);
  localparam int CW          = $clog2(NUM_SECTORS + 1);
  localparam int SS_W        = 16;
  localparam int SC_W        = 7;
  localparam int BYTES_W     = 24;
  localparam int NEED_W      = BYTES_W + 1;
  localparam int USED_W      = 7;

  localparam logic [SS_W-1:0] SECTOR_SIZE_RESET  = SS_W'(1024);
  localparam logic [SC_W-1:0] SECTOR_COUNT_RESET = SC_W'(64);
  localparam logic [ID_W-1:0] ID_MAX             = '1;

  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_DELETE  = 2'd1,
    OP_FORMAT  = 2'd2,
    OP_DEFRAG  = 2'd3
  } op_e;

  typedef enum logic {
    CFG_SECTOR_SIZE  = 1'b0,
    CFG_SECTOR_COUNT = 1'b1
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DIV,
    ST_CHECK,
    ST_RD,
    ST_USE,
    ST_FLUSH,
    ST_COMMIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic div_start;
    logic clr_idx;
    logic clr_pass;
    logic rd;
    logic step;
    logic flush;
    logic commit;
    logic format;
    logic out_valid;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic div_done;
    logic fail;
    logic idx_last;
    logic pass_last;
  } sts_t;

endpackage

FILE: design/sat_div.sv
module sat_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sat_pkg::BYTES_W-1:0] dividend_i,
  input  logic [sat_pkg::SS_W-1:0]    divisor_i,
  output logic                        done_o,
  output logic [sat_pkg::NEED_W-1:0]  need_o
);

  localparam int CNT_W = $clog2(sat_pkg::BYTES_W + 1);

  logic [sat_pkg::BYTES_W-1:0] quo_q, quo_d;
  logic [sat_pkg::SS_W:0]      rem_q, rem_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        run_q, run_d;
  logic [sat_pkg::SS_W:0]      rem_sh;
  logic [sat_pkg::SS_W-1:0]    dvs;

  // a zero sector size counts as one
  assign dvs    = (divisor_i == '0) ? sat_pkg::SS_W'(1) : divisor_i;
  assign rem_sh = {rem_q[sat_pkg::SS_W-1:0], quo_q[sat_pkg::BYTES_W-1]};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    run_d = run_q;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = CNT_W'(sat_pkg::BYTES_W);
      run_d = 1'b1;
    end else if (run_q) begin
      if (rem_sh >= {1'b0, dvs}) begin
        rem_d = rem_sh - {1'b0, dvs};
        quo_d = {quo_q[sat_pkg::BYTES_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[sat_pkg::BYTES_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  // round up when a remainder is left
  assign done_o = !run_q && !start_i;
  assign need_o = {1'b0, quo_q} + sat_pkg::NEED_W'(rem_q != '0);

endmodule

FILE: design/sat_dp.sv
module sat_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_index_i,
  input  logic [15:0]                 cfg_data_i,
  input  logic [1:0]                  opcode_i,
  input  logic [sat_pkg::BYTES_W-1:0] size_bytes_i,
  input  logic [sat_pkg::ID_W-1:0]    file_id_i,
  input  sat_pkg::cmd_t               cmd_i,
  output sat_pkg::sts_t               sts_o,
  output logic [sat_pkg::ID_W-1:0]    granted_id_o,
  output logic [sat_pkg::USED_W-1:0]  used_sectors_o
);

  localparam int AW = sat_pkg::AW;
  localparam int CW = sat_pkg::CW;
  localparam int IW = sat_pkg::ID_W;

  logic [sat_pkg::SS_W-1:0]    ss_q;
  logic [sat_pkg::SC_W-1:0]    sc_q;
  sat_pkg::op_e                op_q;
  logic [sat_pkg::BYTES_W-1:0] bytes_q;
  logic [IW-1:0]               fid_q;
  logic [CW-1:0]               used_q, used_d;
  logic [IW-1:0]               next_id_q, next_id_d;
  logic [IW-1:0]               granted_q;
  logic [CW-1:0]               idx_q, idx_d;
  logic [CW-1:0]               pass_q, pass_d;
  logic [CW-1:0]               got_q, got_d;
  logic [IW-1:0]               carry_q, carry_d;

  logic [IW-1:0]               mem [sat_pkg::NUM_SECTORS];
  logic [sat_pkg::NUM_SECTORS-1:0] vld_q;
  logic [IW-1:0]               rdata_q;
  logic                        rvld_q;

  logic [CW-1:0]               n_act, room;
  logic [IW-1:0]               entry;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [IW-1:0]               wr_data;
  logic                        div_done;
  logic [sat_pkg::NEED_W-1:0]  need;
  logic                        take;

  sat_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (bytes_q),
    .divisor_i  (ss_q),
    .done_o     (div_done),
    .need_o     (need)
  );

  always_comb begin
    if (sc_q == '0) n_act = CW'(1);
    else if (int'(sc_q) > sat_pkg::NUM_SECTORS) n_act = CW'(sat_pkg::NUM_SECTORS);
    else n_act = CW'(sc_q);
  end

  assign room  = (used_q >= n_act) ? '0 : n_act - used_q;
  assign entry = rvld_q ? rdata_q : '0;
  assign take  = (entry == '0) && (sat_pkg::NEED_W'(got_q) < need);

  // single write port: scan step or end-of-pass flush
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q[AW-1:0];
    wr_data = '0;
    if (cmd_i.step) begin
      case (op_q)
        sat_pkg::OP_RESERVE: begin
          wr_en   = take;
          wr_data = next_id_q;
        end
        sat_pkg::OP_DELETE: begin
          wr_en   = (entry == fid_q);
        end
        sat_pkg::OP_DEFRAG: begin
          wr_en   = (idx_q != '0);
          wr_addr = AW'(idx_q - CW'(1));
          wr_data = (carry_q < entry) ? entry : carry_q;
        end
        default: wr_en = 1'b0;
      endcase
    end else if (cmd_i.flush) begin
      wr_en   = 1'b1;
      wr_addr = AW'(n_act - CW'(1));
      wr_data = carry_q;
    end
  end

  always_comb begin
    used_d    = used_q;
    next_id_d = next_id_q;
    idx_d     = idx_q;
    pass_d    = pass_q;
    got_d     = got_q;
    carry_d   = carry_q;
    if (cmd_i.clr_idx) begin
      idx_d = '0;
      got_d = '0;
    end
    if (cmd_i.clr_pass) pass_d = '0;
    if (cmd_i.step) begin
      idx_d = idx_q + CW'(1);
      case (op_q)
        sat_pkg::OP_RESERVE: if (take) got_d = got_q + CW'(1);
        sat_pkg::OP_DELETE: if (entry == fid_q && used_q != '0) used_d = used_q - CW'(1);
        sat_pkg::OP_DEFRAG: begin
          if (idx_q == '0) carry_d = entry;
          else if (carry_q >= entry) carry_d = entry;
        end
        default: carry_d = carry_q;
      endcase
    end
    if (cmd_i.flush) begin
      idx_d  = '0;
      pass_d = pass_q + CW'(1);
    end
    if (cmd_i.commit) begin
      used_d    = used_q + got_q;
      next_id_d = (next_id_q == sat_pkg::ID_MAX) ? '0 : next_id_q + IW'(1);
    end
    if (cmd_i.format) begin
      used_d    = '0;
      next_id_d = IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ss_q      <= sat_pkg::SECTOR_SIZE_RESET;
      sc_q      <= sat_pkg::SECTOR_COUNT_RESET;
      used_q    <= '0;
      next_id_q <= IW'(1);
      idx_q     <= '0;
      pass_q    <= '0;
      got_q     <= '0;
      vld_q     <= '0;
      granted_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == sat_pkg::CFG_SECTOR_SIZE) ss_q <= cfg_data_i;
        else sc_q <= cfg_data_i[sat_pkg::SC_W-1:0];
      end
      used_q    <= used_d;
      next_id_q <= next_id_d;
      idx_q     <= idx_d;
      pass_q    <= pass_d;
      got_q     <= got_d;
      if (cmd_i.format) vld_q <= '0;
      else if (wr_en) vld_q[wr_addr] <= 1'b1;
      if (cmd_i.load) granted_q <= '0;
      else if (cmd_i.commit) granted_q <= next_id_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= sat_pkg::op_e'(opcode_i);
      bytes_q <= size_bytes_i;
      fid_q   <= file_id_i;
    end
    carry_q <= carry_d;
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd_i.rd) begin
      rdata_q <= mem[idx_q[AW-1:0]];
      rvld_q  <= vld_q[idx_q[AW-1:0]];
    end
  end

  always_comb begin
    sts_o.op        = op_q;
    sts_o.div_done  = div_done;
    sts_o.idx_last  = (idx_q == n_act - CW'(1));
    sts_o.pass_last = (pass_q == n_act - CW'(1));
    if (op_q == sat_pkg::OP_DELETE) sts_o.fail = (fid_q == '0);
    else sts_o.fail = (bytes_q == '0) || (next_id_q == '0) ||
                      (need > sat_pkg::NEED_W'(room));
  end

  assign granted_id_o   = granted_q;
  assign used_sectors_o = sat_pkg::USED_W'(used_q);

endmodule

FILE: design/sat_ctrl.sv
module sat_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  sat_pkg::sts_t sts_i,
  output sat_pkg::cmd_t cmd_o,
  output logic          busy
);

  sat_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= sat_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = (state_q != sat_pkg::ST_IDLE);
    case (state_q)
      sat_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = sat_pkg::ST_DISPATCH;
        end
      end
      sat_pkg::ST_DISPATCH: begin
        case (sts_i.op)
          sat_pkg::OP_RESERVE: begin
            cmd_o.div_start = 1'b1;
            state_d         = sat_pkg::ST_DIV;
          end
          sat_pkg::OP_DELETE: begin
            cmd_o.clr_idx = 1'b1;
            state_d       = sts_i.fail ? sat_pkg::ST_DONE : sat_pkg::ST_RD;
          end
          sat_pkg::OP_FORMAT: begin
            cmd_o.format = 1'b1;
            state_d      = sat_pkg::ST_DONE;
          end
          default: begin
            cmd_o.clr_idx  = 1'b1;
            cmd_o.clr_pass = 1'b1;
            state_d        = sat_pkg::ST_RD;
          end
        endcase
      end
      sat_pkg::ST_DIV: begin
        if (sts_i.div_done) state_d = sat_pkg::ST_CHECK;
      end
      sat_pkg::ST_CHECK: begin
        cmd_o.clr_idx = 1'b1;
        state_d       = sts_i.fail ? sat_pkg::ST_DONE : sat_pkg::ST_RD;
      end
      sat_pkg::ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = sat_pkg::ST_USE;
      end
      sat_pkg::ST_USE: begin
        cmd_o.step = 1'b1;
        if (!sts_i.idx_last) state_d = sat_pkg::ST_RD;
        else if (sts_i.op == sat_pkg::OP_DEFRAG) state_d = sat_pkg::ST_FLUSH;
        else if (sts_i.op == sat_pkg::OP_RESERVE) state_d = sat_pkg::ST_COMMIT;
        else state_d = sat_pkg::ST_DONE;
      end
      sat_pkg::ST_FLUSH: begin
        // one bubble pass ends, smallest id sinks to the tail
        cmd_o.flush = 1'b1;
        state_d     = sts_i.pass_last ? sat_pkg::ST_DONE : sat_pkg::ST_RD;
      end
      sat_pkg::ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = sat_pkg::ST_DONE;
      end
      sat_pkg::ST_DONE: begin
        cmd_o.out_valid = 1'b1;
        state_d         = sat_pkg::ST_IDLE;
      end
      default: state_d = sat_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: design/sector_allocation_table.sv
// Command-style sector allocation table. A command is taken when start is high while busy
// is low; exactly one result follows, shown for a single cycle with result_valid_o, and
// the receiver cannot stall it. Commands are format, delete (which ends early when the
// id is zero), reserve (the 24-step restoring divider for the sector count, then one
// read/modify step per sector on the single-port table memory; a failing reserve ends
// after the divider) and defragment (n bubble passes over the table, with n active
// sectors). The table is cleared at reset and format through per-sector valid flags,
// so no clearing pass runs.
// Configuration writes are always taken (cfg_ready_o is tied high).
module sector_allocation_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode_i,
  input  logic [sat_pkg::BYTES_W-1:0] size_bytes_i,
  input  logic [sat_pkg::ID_W-1:0]    file_id_i,
  output logic                        result_valid_o,
  output logic [sat_pkg::ID_W-1:0]    granted_id_o,
  output logic [sat_pkg::USED_W-1:0]  used_sectors_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_index_i,
  input  logic [15:0]                 cfg_data_i
);

  sat_pkg::cmd_t cmd;
  sat_pkg::sts_t sts;

  sat_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  sat_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .opcode_i       (opcode_i),
    .size_bytes_i   (size_bytes_i),
    .file_id_i      (file_id_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .granted_id_o   (granted_id_o),
    .used_sectors_o (used_sectors_o)
  );

  assign result_valid_o = cmd.out_valid;
  assign cfg_ready_o    = 1'b1;

endmodule

FILE: design/sat_checker.sv
`include "sector_allocation_table_assert.svh"

module sat_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o
);

  // a result strobe lasts one cycle
  `SAT_ASSERT_NEXT(a_strobe_single, result_valid_o, !result_valid_o)
  // an accepted command makes the block busy
  `SAT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // results only appear while a command is in flight
  `SAT_ASSERT_NOW(a_result_busy, result_valid_o, busy)
  // busy drops only right after a result transfer
  `SAT_ASSERT_NOW(a_busy_end, $fell(busy), $past(result_valid_o))

endmodule

bind sector_allocation_table sat_checker u_sat_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o)
);
